>>> design/cals_pkg.sv
// ----------------------------------------------------------------------------
// cals_pkg: shared types and constants of the list scheduler
// Holds the sequencer state type, opcodes, field widths and defaults.
// ----------------------------------------------------------------------------
package cals_pkg;

    localparam int MAX_MACHINES_DEF = 16;
    localparam int MAX_JOBS_DEF     = 64;

    localparam int TIME_W = 32;
    localparam int LEN_W  = 16;
    localparam int JOB_W  = 6;
    localparam int ROW_W  = 64;
    localparam int MACH_W = 4;
    localparam int CFG_W  = 5;
    localparam int FILL_W = 5;

    localparam logic [CFG_W-1:0]  CFG_COUNT_RESET = 5'd16;
    localparam logic [FILL_W-1:0] FILLED_MAX      = 5'd31;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CONF,
        ST_PLACE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

>>> design/conflict_aware_list_scheduler.sv
// ----------------------------------------------------------------------------
// conflict_aware_list_scheduler: greedy least-loaded list scheduler
// Places each job on the least-loaded machine, delayed past every machine
// whose last job conflicts with it, then rescans for the next machine.
//
//   channel   handshake              payload
//   input     start / busy           i_opcode, i_job_id, i_job_length,
//                                    i_conflict_row
//   result    o_result_valid strobe  o_assigned_machine, o_job_finish,
//                                    o_makespan, o_next_machine,
//                                    o_next_min_time
//   config    i_cfg_we               i_cfg_wdata (machine count)
//
// A start beat passes through ST_START and ST_DONE and strobes its result in
// ST_DONE. An append beat passes through ST_CONF, ST_PLACE, ST_SCAN and
// ST_DONE and strobes its result in ST_DONE: the machine table is walked
// twice, for the conflict maximum and for the minimum, through one read port
// and one shared comparator. The block returns to ST_IDLE after ST_DONE and
// takes the next beat only there. Reset is synchronous and needs
// no clearing pass: per-machine valid bits make unwritten finish times read
// as zero. The receiver cannot stall.
// ----------------------------------------------------------------------------
module conflict_aware_list_scheduler #(
    parameter int MAX_MACHINES = cals_pkg::MAX_MACHINES_DEF,
    parameter int MAX_JOBS     = cals_pkg::MAX_JOBS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cals_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [cals_pkg::JOB_W-1:0] i_job_id,
    input  logic [cals_pkg::LEN_W-1:0] i_job_length,
    input  logic [cals_pkg::ROW_W-1:0] i_conflict_row,
    output logic                        o_result_valid,
    output logic [cals_pkg::MACH_W-1:0] o_assigned_machine,
    output logic [cals_pkg::TIME_W-1:0] o_job_finish,
    output logic [cals_pkg::TIME_W-1:0] o_makespan,
    output logic [cals_pkg::MACH_W-1:0] o_next_machine,
    output logic [cals_pkg::TIME_W-1:0] o_next_min_time
);

    localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CNT_W = $clog2(MAX_MACHINES + 1);
    localparam int EXT_W = 8;

    cals_pkg::t_state r_state, n_state;

    logic [cals_pkg::CFG_W-1:0]  r_cfg_count;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [cals_pkg::JOB_W-1:0]  r_job, n_job;
    logic [cals_pkg::LEN_W-1:0]  r_len, n_len;
    logic [cals_pkg::ROW_W-1:0]  r_row, n_row;
    logic [cals_pkg::TIME_W-1:0] r_start, n_start;
    logic [CNT_W-1:0]            r_scan, n_scan;
    logic [IDX_W-1:0]            r_target, n_target;
    logic [CNT_W-1:0]            r_idx, n_idx;
    logic                        r_rd_vld, n_rd_vld;
    logic                        r_rd_first, n_rd_first;
    logic [cals_pkg::TIME_W-1:0] r_least_time, n_least_time;
    logic [IDX_W-1:0]            r_least_machine, n_least_machine;
    logic [cals_pkg::TIME_W-1:0] r_makespan, n_makespan;
    logic [cals_pkg::FILL_W-1:0] r_filled, n_filled;
    logic [MAX_MACHINES-1:0]     r_valid, n_valid;
    logic [IDX_W-1:0]            r_out_machine, n_out_machine;
    logic [cals_pkg::TIME_W-1:0] r_out_finish, n_out_finish;

    // Machine table: finish time and last job per machine.
    logic [cals_pkg::TIME_W-1:0] finish_mem [MAX_MACHINES];
    logic [cals_pkg::JOB_W-1:0]  lastjob_mem [MAX_MACHINES];
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [cals_pkg::TIME_W-1:0] mem_wfin;
    logic [cals_pkg::JOB_W-1:0]  mem_wjob;
    logic [IDX_W-1:0]            rd_addr;
    logic [cals_pkg::TIME_W-1:0] r_rd_fin;
    logic [cals_pkg::JOB_W-1:0]  r_rd_job;
    logic                        r_rd_fin_vld;

    // Shared comparator and helpers.
    logic [cals_pkg::TIME_W-1:0] cmp_a, cmp_b;
    logic                        cmp_lt;
    logic [cals_pkg::TIME_W-1:0] fin_eff;
    logic [cals_pkg::TIME_W:0]   sum;
    logic [cals_pkg::TIME_W-1:0] place_finish;
    logic [EXT_W-1:0]            cfg_x, filled_x, count_x, act_x, least_x;
    logic [CNT_W-1:0]            act_count;
    logic                        conflict;
    logic                        issue;

    assign rd_addr = r_idx[IDX_W-1:0];
    assign fin_eff = r_rd_fin_vld ? r_rd_fin : '0;
    assign sum = {1'b0, r_start} + {{(cals_pkg::TIME_W + 1 - cals_pkg::LEN_W){1'b0}}, r_len};
    assign place_finish = sum[cals_pkg::TIME_W] ? '1 : sum[cals_pkg::TIME_W-1:0];
    assign conflict = ({1'b0, r_rd_job} < 7'(MAX_JOBS)) && r_row[r_rd_job];

    // A machine count of zero means one; anything above the bank means all.
    always_comb begin
        cfg_x = EXT_W'(r_cfg_count);
        if (cfg_x == '0) begin
            act_x = EXT_W'(1);
        end else if (cfg_x > EXT_W'(MAX_MACHINES)) begin
            act_x = EXT_W'(MAX_MACHINES);
        end else begin
            act_x = cfg_x;
        end
        act_count = act_x[CNT_W-1:0];
    end

    always_comb begin
        unique case (r_state)
            cals_pkg::ST_CONF: begin
                cmp_a = r_start;
                cmp_b = fin_eff;
            end
            cals_pkg::ST_PLACE: begin
                cmp_a = r_makespan;
                cmp_b = place_finish;
            end
            default: begin
                cmp_a = fin_eff;
                cmp_b = r_least_time;
            end
        endcase
        cmp_lt = cmp_a < cmp_b;
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_job           = r_job;
        n_len           = r_len;
        n_row           = r_row;
        n_start         = r_start;
        n_scan          = r_scan;
        n_target        = r_target;
        n_idx           = r_idx;
        n_rd_vld        = 1'b0;
        n_rd_first      = r_rd_first;
        n_least_time    = r_least_time;
        n_least_machine = r_least_machine;
        n_makespan      = r_makespan;
        n_filled        = r_filled;
        n_valid         = r_valid;
        n_out_machine   = r_out_machine;
        n_out_finish    = r_out_finish;
        mem_we          = 1'b0;
        mem_waddr       = r_target;
        mem_wfin        = place_finish;
        mem_wjob        = r_job;
        issue           = 1'b0;
        filled_x        = EXT_W'(r_filled);
        count_x         = act_x;
        least_x         = EXT_W'(r_least_machine);

        unique case (r_state)
            cals_pkg::ST_IDLE: begin
                if (start) begin
                    n_count = act_count;
                    n_job   = i_job_id;
                    n_len   = i_job_length;
                    n_row   = i_conflict_row;
                    n_start = r_least_time;
                    n_idx   = '0;
                    n_scan  = (filled_x < count_x) ? CNT_W'(r_filled) : act_count;
                    if (least_x < count_x) begin
                        n_target = r_least_machine;
                    end else begin
                        n_target = IDX_W'(act_count - CNT_W'(1));
                    end
                    n_state = (i_opcode == cals_pkg::OP_START) ? cals_pkg::ST_START
                                                               : cals_pkg::ST_CONF;
                end
            end
            cals_pkg::ST_START: begin
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wfin      = cals_pkg::TIME_W'(r_len);
                n_valid       = '0;
                n_valid[0]    = 1'b1;
                n_filled      = cals_pkg::FILL_W'(1);
                n_makespan    = cals_pkg::TIME_W'(r_len);
                n_out_machine = '0;
                n_out_finish  = cals_pkg::TIME_W'(r_len);
                if (r_count > CNT_W'(1)) begin
                    n_least_machine = IDX_W'(1);
                    n_least_time    = '0;
                end else begin
                    n_least_machine = '0;
                    n_least_time    = cals_pkg::TIME_W'(r_len);
                end
                n_state = cals_pkg::ST_DONE;
            end
            cals_pkg::ST_CONF: begin
                // Reads are issued one machine a cycle; data returns in the next cycle.
                issue = r_idx < r_scan;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_rd_vld = issue;
                if (r_rd_vld && conflict && cmp_lt) begin
                    n_start = fin_eff;
                end
                if (!issue && !r_rd_vld) begin
                    n_state = cals_pkg::ST_PLACE;
                end
            end
            cals_pkg::ST_PLACE: begin
                mem_we            = 1'b1;
                n_valid[r_target] = 1'b1;
                if (cmp_lt) begin
                    n_makespan = place_finish;
                end
                if (r_filled < cals_pkg::FILLED_MAX) begin
                    n_filled = r_filled + cals_pkg::FILL_W'(1);
                end
                n_out_machine = r_target;
                n_out_finish  = place_finish;
                n_idx         = '0;
                n_state       = cals_pkg::ST_SCAN;
            end
            cals_pkg::ST_SCAN: begin
                issue = r_idx < r_count;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_rd_vld   = issue;
                n_rd_first = (r_idx == '0);
                // The first machine seeds the minimum; later ones win only if strictly less.
                if (r_rd_vld && (r_rd_first || cmp_lt)) begin
                    n_least_time    = fin_eff;
                    n_least_machine = IDX_W'(r_idx - CNT_W'(1));
                end
                if (!issue && !r_rd_vld) begin
                    n_state = cals_pkg::ST_DONE;
                end
            end
            cals_pkg::ST_DONE: begin
                n_state = cals_pkg::ST_IDLE;
            end
            default: begin
                n_state = cals_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cals_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count     <= cals_pkg::CFG_COUNT_RESET;
            r_rd_vld        <= 1'b0;
            r_least_time    <= '0;
            r_least_machine <= '0;
            r_makespan      <= '0;
            r_filled        <= '0;
            r_valid         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_wdata;
            end
            r_rd_vld        <= n_rd_vld;
            r_least_time    <= n_least_time;
            r_least_machine <= n_least_machine;
            r_makespan      <= n_makespan;
            r_filled        <= n_filled;
            r_valid         <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count       <= n_count;
        r_job         <= n_job;
        r_len         <= n_len;
        r_row         <= n_row;
        r_start       <= n_start;
        r_scan        <= n_scan;
        r_target      <= n_target;
        r_idx         <= n_idx;
        r_rd_first    <= n_rd_first;
        r_out_machine <= n_out_machine;
        r_out_finish  <= n_out_finish;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            finish_mem[mem_waddr]  <= mem_wfin;
            lastjob_mem[mem_waddr] <= mem_wjob;
        end
        r_rd_fin     <= finish_mem[rd_addr];
        r_rd_job     <= lastjob_mem[rd_addr];
        r_rd_fin_vld <= r_valid[rd_addr];
    end

    assign busy               = (r_state != cals_pkg::ST_IDLE);
    assign o_result_valid     = (r_state == cals_pkg::ST_DONE);
    assign o_assigned_machine = cals_pkg::MACH_W'(r_out_machine);
    assign o_job_finish       = r_out_finish;
    assign o_makespan         = r_makespan;
    assign o_next_machine     = cals_pkg::MACH_W'(r_least_machine);
    assign o_next_min_time    = r_least_time;

endmodule

>>> design/cals_checker.sv
// ----------------------------------------------------------------------------
// cals_checker: port-level checks for the list scheduler
// Watches the handshake and the result beat relations over time.
// ----------------------------------------------------------------------------
module cals_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic [cals_pkg::TIME_W-1:0] o_job_finish,
    input logic [cals_pkg::TIME_W-1:0] o_makespan,
    input logic [cals_pkg::TIME_W-1:0] o_next_min_time
);

    // An accepted beat keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a beat");

    // A result beat only appears while an item is in flight.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    // Exactly one result per item: the strobe is never held.
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // The makespan bounds both the placed job and the least-loaded machine.
    a_makespan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_makespan >= o_job_finish) && (o_makespan >= o_next_min_time))
        else $error("makespan below a machine finish time");

endmodule

bind conflict_aware_list_scheduler cals_checker u_cals_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_job_finish   (o_job_finish),
    .o_makespan     (o_makespan),
    .o_next_min_time(o_next_min_time)
);
